>>> rtl/msrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msrp_pkg;

   localparam int NUM_SERVOS = 4;
   localparam int FRAC_BITS  = 16;

   localparam int SRV_W  = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
   localparam int INT_W  = 12;
   localparam int POS_W  = INT_W + FRAC_BITS;
   localparam int STEP_W = POS_W + 1;
   localparam int MS_W   = 14;
   localparam int DIV_W  = POS_W + 5;
   localparam int SLOT_W = 16;
   localparam int LINE_W = 4;

   localparam int PULSE_MIN   = 500;
   localparam int PULSE_MAX   = 2500;
   localparam int MOVE_MAX_MS = 10000;
   localparam int FRAME_MS    = 20;
   localparam int CENTER_US   = 1500;
   localparam int SLOT_RESET  = 3000;

   localparam logic FUNC_SET   = 1'b0;
   localparam logic FUNC_TIMER = 1'b1;

   typedef struct packed {
      logic [POS_W-1:0]  pos;
      logic [STEP_W-1:0] step;
      logic [INT_W-1:0]  target;
   } entry_type;

   localparam entry_type RESET_ENTRY = '{
      pos:    POS_W'(CENTER_US) << FRAC_BITS,
      step:   '0,
      target: INT_W'(CENTER_US)
   };

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [MS_W-1:0]  divisor;
   } div_req_type;

endpackage

`default_nettype wire

>>> rtl/msrp_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface msrp_req_if;
   import msrp_pkg::*;

   logic             valid;
   logic             ready;
   logic             func;
   logic [7:0]       servo;
   logic [15:0]      target_us;
   logic [15:0]      move_ms;

   modport source (output valid, output func, output servo, output target_us,
                   output move_ms, input ready);
   modport sink   (input valid, input func, input servo, input target_us,
                   input move_ms, output ready);
endinterface

`default_nettype wire

>>> rtl/msrp_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface msrp_rsp_if;
   import msrp_pkg::*;

   logic              valid;
   logic              ready;
   logic              accepted;
   logic [LINE_W-1:0] line_servo;
   logic              line_level;
   logic [SLOT_W-1:0] interval_us;
   logic              moving;

   modport source (output valid, output accepted, output line_servo, output line_level,
                   output interval_us, output moving, input ready);
   modport sink   (input valid, input accepted, input line_servo, input line_level,
                   input interval_us, input moving, output ready);
endinterface

`default_nettype wire

>>> rtl/msrp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module msrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

`default_nettype wire

>>> rtl/msrp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module msrp_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire msrp_pkg::div_req_type       req,
   output      logic                        done,
   output      logic [msrp_pkg::POS_W-1:0]  quotient
);
   import msrp_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [MS_W-1:0]    rem_ff;
   logic [DIV_W-1:0]   quo_ff;
   logic [MS_W-1:0]    divisor_ff;
   logic [MS_W:0]      trial;
   logic               fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff    <= 1'b1;
            cnt_ff     <= CNT_W'(DIV_W);
            rem_ff     <= '0;
            quo_ff     <= req.dividend;
            divisor_ff <= req.divisor;
         end else if (busy_ff) begin
            rem_ff <= fits ? MS_W'(trial - {1'b0, divisor_ff}) : trial[MS_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff[POS_W-1:0];
endmodule

`default_nettype wire

>>> rtl/multi_servo_ramp_pwm_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Fields                                             Use
// req_ch   in   func servo target_us move_ms                       set_target / timer beat
// rsp_ch   out  accepted line_servo line_level interval_us moving  one beat per req beat
// csr      in   csr_wr_en csr_wr_data                              slot length in us
//
// A timer beat, or a set_target that needs no ramp, passes through S_CALC and S_EMIT to
// the response register; the next beat is taken only once the core is back in S_IDLE.
// A ramped set_target also waits in S_DIV for the 33-step bit-serial divider.
// Servo state lives in one RAM; per-entry valid bits give the reset values.
// One beat is in flight at a time; a full response register stalls only the last step.

module multi_servo_ramp_pwm_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [msrp_pkg::SLOT_W-1:0]  csr_wr_data,
   msrp_req_if.sink                          req_ch,
   msrp_rsp_if.source                        rsp_ch
);
   import msrp_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_CALC, S_DIV, S_EMIT} state_type;

   state_type            state_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SRV_W-1:0]     active_ff;
   logic                 phase_ff;
   logic [NUM_SERVOS-1:0] valid_ff;
   logic [NUM_SERVOS-1:0] moving_ff;
   logic                 rd_valid_ff;

   logic                 func_ff;
   logic                 in_range_ff;
   logic [SRV_W-1:0]     addr_ff;
   logic [15:0]          aim_ff;
   logic [15:0]          tms_ff;
   entry_type            ent_ff;
   logic                 diff_neg_ff;
   logic                 diff_nz_ff;

   logic                 res_accepted_ff;
   logic [LINE_W-1:0]    res_servo_ff;
   logic                 res_level_ff;
   logic [SLOT_W-1:0]    res_interval_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_accepted_ff;
   logic [LINE_W-1:0]    rsp_servo_ff;
   logic                 rsp_level_ff;
   logic [SLOT_W-1:0]    rsp_interval_ff;
   logic                 rsp_moving_ff;

   logic                 accept;
   logic [SRV_W-1:0]     rd_addr;
   entry_type            ram_rdata;
   entry_type            ent;
   logic                 ram_wr_en;
   entry_type            ram_wdata;

   logic [INT_W-1:0]     aim_clamp;
   logic [MS_W-1:0]      tms_clamp;
   logic [POS_W-1:0]     aim_fix;
   logic signed [STEP_W-1:0] diff;
   logic [STEP_W-1:0]    diff_abs;
   logic [POS_W-1:0]     diff_mag;
   logic                 short_move;

   logic [POS_W-1:0]     tgt_fix;
   logic signed [STEP_W-1:0] left;
   logic signed [STEP_W-1:0] inc;
   logic signed [STEP_W-1:0] pos_sum;
   logic                 snap;
   logic [POS_W-1:0]     new_pos;
   logic [POS_W-1:0]     pulse_pos;
   logic [INT_W-1:0]     pulse_int;
   logic [INT_W-1:0]     pulse;

   div_req_type          div_req;
   logic                 div_done;
   logic [POS_W-1:0]     div_q;
   logic [STEP_W-1:0]    q_ext;
   logic [STEP_W-1:0]    div_step;
   logic                 emit_load;

   assign accept  = req_ch.valid && req_ch.ready;
   assign rd_addr = (req_ch.func == FUNC_TIMER) ? active_ff : req_ch.servo[SRV_W-1:0];
   assign ent     = rd_valid_ff ? ram_rdata : RESET_ENTRY;

   always_comb begin
      if (aim_ff < 16'(PULSE_MIN)) begin
         aim_clamp = INT_W'(PULSE_MIN);
      end else if (aim_ff > 16'(PULSE_MAX)) begin
         aim_clamp = INT_W'(PULSE_MAX);
      end else begin
         aim_clamp = aim_ff[INT_W-1:0];
      end
      tms_clamp = (tms_ff > 16'(MOVE_MAX_MS)) ? MS_W'(MOVE_MAX_MS) : tms_ff[MS_W-1:0];
   end

   assign aim_fix    = {aim_clamp, {FRAC_BITS{1'b0}}};
   assign diff       = $signed({1'b0, aim_fix}) - $signed({1'b0, ent.pos});
   assign diff_abs   = diff[STEP_W-1] ? STEP_W'(-diff) : STEP_W'(diff);
   assign diff_mag   = diff_abs[POS_W-1:0];
   assign short_move = tms_clamp < MS_W'(FRAME_MS);

   assign div_req.start    = (state_ff == S_CALC) && (func_ff == FUNC_SET) && !short_move;
   assign div_req.dividend = (DIV_W'(diff_mag) << 4) + (DIV_W'(diff_mag) << 2);
   assign div_req.divisor  = tms_clamp;

   assign tgt_fix = {ent.target, {FRAC_BITS{1'b0}}};
   assign left    = $signed({1'b0, tgt_fix}) - $signed({1'b0, ent.pos});
   assign inc     = $signed(ent.step);
   assign pos_sum = $signed({1'b0, ent.pos}) + inc;
   assign snap    = ((inc > 0) && (left <= inc)) || ((inc < 0) && (left >= inc));

   always_comb begin
      if (inc == 0) begin
         new_pos = ent.pos;
      end else if (snap) begin
         new_pos = tgt_fix;
      end else begin
         new_pos = pos_sum[POS_W-1:0];
      end
      pulse_pos = phase_ff ? ent.pos : new_pos;
      pulse_int = pulse_pos[POS_W-1:FRAC_BITS];
      if (pulse_int < INT_W'(PULSE_MIN)) begin
         pulse = INT_W'(PULSE_MIN);
      end else if (pulse_int > INT_W'(PULSE_MAX)) begin
         pulse = INT_W'(PULSE_MAX);
      end else begin
         pulse = pulse_int;
      end
   end

   assign q_ext = STEP_W'(div_q);
   always_comb begin
      if (div_q == '0 && diff_nz_ff) begin
         div_step = diff_neg_ff ? '1 : STEP_W'(1);
      end else begin
         div_step = diff_neg_ff ? STEP_W'(-q_ext) : q_ext;
      end
   end

   always_comb begin
      ram_wr_en = 1'b0;
      ram_wdata = ent;
      if (state_ff == S_CALC) begin
         if (func_ff == FUNC_TIMER) begin
            ram_wr_en = !phase_ff;
            ram_wdata = '{pos: new_pos, step: (snap ? '0 : ent.step), target: ent.target};
         end else if (in_range_ff && short_move) begin
            ram_wr_en = 1'b1;
            ram_wdata = '{pos: aim_fix, step: '0, target: aim_clamp};
         end
      end else if (state_ff == S_DIV && div_done) begin
         ram_wr_en = 1'b1;
         ram_wdata = '{pos: ent_ff.pos, step: div_step, target: ent_ff.target};
      end
   end

   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   msrp_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (NUM_SERVOS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   msrp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_ff      <= SLOT_W'(SLOT_RESET);
         active_ff    <= '0;
         phase_ff     <= 1'b0;
         valid_ff     <= '0;
         moving_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            slot_ff <= csr_wr_data;
         end
         if (ram_wr_en) begin
            valid_ff[addr_ff]  <= 1'b1;
            moving_ff[addr_ff] <= ram_wdata.step != '0;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  func_ff     <= req_ch.func;
                  in_range_ff <= req_ch.servo < 8'(NUM_SERVOS);
                  addr_ff     <= rd_addr;
                  aim_ff      <= req_ch.target_us;
                  tms_ff      <= req_ch.move_ms;
                  rd_valid_ff <= valid_ff[rd_addr];
                  state_ff    <= S_CALC;
               end
            end
            S_CALC: begin
               ent_ff          <= '{pos: ent.pos, step: ent.step, target: aim_clamp};
               diff_neg_ff     <= diff[STEP_W-1];
               diff_nz_ff      <= diff != 0;
               res_accepted_ff <= in_range_ff || (func_ff == FUNC_TIMER);
               if (func_ff == FUNC_TIMER) begin
                  res_servo_ff <= LINE_W'(addr_ff);
                  res_level_ff <= !phase_ff;
                  phase_ff     <= !phase_ff;
                  state_ff     <= S_EMIT;
                  if (!phase_ff) begin
                     res_interval_ff <= SLOT_W'(pulse);
                  end else begin
                     res_interval_ff <= (slot_ff > SLOT_W'(pulse)) ?
                                        slot_ff - SLOT_W'(pulse) : '0;
                     active_ff <= (addr_ff == SRV_W'(NUM_SERVOS - 1)) ?
                                  '0 : addr_ff + 1'b1;
                  end
               end else begin
                  res_servo_ff    <= '0;
                  res_level_ff    <= 1'b0;
                  res_interval_ff <= '0;
                  state_ff        <= (in_range_ff && !short_move) ? S_DIV : S_EMIT;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (emit_load) begin
                  rsp_accepted_ff <= res_accepted_ff;
                  rsp_servo_ff    <= res_servo_ff;
                  rsp_level_ff    <= res_level_ff;
                  rsp_interval_ff <= res_interval_ff;
                  rsp_moving_ff   <= |moving_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.accepted    = rsp_accepted_ff;
   assign rsp_ch.line_servo  = rsp_servo_ff;
   assign rsp_ch.line_level  = rsp_level_ff;
   assign rsp_ch.interval_us = rsp_interval_ff;
   assign rsp_ch.moving      = rsp_moving_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("input beat accepted while another is in flight");

   a_write_in_calc: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_CALC || state_ff == S_DIV))
      else $error("state RAM written outside the update states");

   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.line_level) |->
         (rsp_ch.interval_us >= 16'(PULSE_MIN) && rsp_ch.interval_us <= 16'(PULSE_MAX)))
      else $error("high-phase pulse outside the servo range");

endmodule

`default_nettype wire
